[hw/rtl/spfl_pkg.sv]
`default_nettype none
package spfl_pkg;

	localparam int NUM_SLOTS_DEF = 32;
	localparam int SLOT_ID_W     = 5;
	localparam int TDATA_W       = 8;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_LIST  = 2'd2,
		OP_BAD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD_LEFT,
		CELL_LOAD_RIGHT,
		CELL_LOAD_BCAST
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     seen_clr;
		logic     seen_step;
		logic     cmp_en;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEARCH,
		ST_FINISH,
		ST_LIST
	} state_t;

endpackage
`default_nettype wire

[hw/rtl/spfl_cell.sv]
`default_nettype none
module spfl_cell #(
	parameter int W   = 5,
	parameter int RST = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire spfl_pkg::cell_ctrl_t ctrl,
	input  wire logic [W-1:0]        key,
	input  wire logic [W-1:0]        left_val,
	input  wire logic [W-1:0]        right_val,
	input  wire logic [W-1:0]        bcast_val,
	input  wire logic                seen_in,
	output logic      [W-1:0]        val,
	output logic                     seen
);

	logic [W-1:0] val_q;
	logic         seen_q;
	logic         match;

	assign match = ctrl.cmp_en && (val_q == key);
	assign val   = val_q;
	assign seen  = seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= W'(RST);
		end else begin
			case (ctrl.op)
				spfl_pkg::CELL_LOAD_LEFT:  val_q <= left_val;
				spfl_pkg::CELL_LOAD_RIGHT: val_q <= right_val;
				spfl_pkg::CELL_LOAD_BCAST: val_q <= bcast_val;
				default:                   val_q <= val_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (ctrl.seen_clr) begin
			seen_q <= 1'b0;
		end else if (ctrl.seen_step) begin
			seen_q <= seen_in | match;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/slot_pool_free_list_allocator.sv]
// Slot pool allocator with a free stack and an in-use list kept in allocation order.
// Input channel s_*: one item per request; s_tdata holds op in bits [1:0]
// (allocate, free, list) and slot_number in bits [6:2].
// Output channel m_*: m_tdata holds ok in bit 0 and slot_id in bits [5:1];
// m_tlast marks the final result of a request.
// Allocate and an unknown op give one result, registered from EXEC into the output register.
// For free, the match flag ripples one cell per cycle down the in-use chain,
// and the chain then closes the gap in one step.
// List gives one result per cycle while the receiver takes them, rotating the
// in-use chain by one cell per result; an empty list gives one failing result.
// A new request is taken only when the previous one has put out its last result,
// and the output register lets that happen while the final result still waits.
// When the receiver stalls, the block holds its result and leaves the slot numbers in both chains unchanged.
// Reset empties the in-use list and loads the free stack with slots in order,
// so the first allocation returns slot 0.
`default_nettype none
module slot_pool_free_list_allocator #(
	parameter int NUM_SLOTS = spfl_pkg::NUM_SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// Bits from low: op[1:0], slot_number[6:2], zero pad.
	input  wire logic [spfl_pkg::TDATA_W-1:0]  s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// Bits from low: ok[0], slot_id[5:1], zero pad.
	output logic      [spfl_pkg::TDATA_W-1:0]  m_tdata,
	output logic                               m_tlast
);

	localparam int IDW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW  = $clog2(NUM_SLOTS + 1);
	localparam int SW  = spfl_pkg::SLOT_ID_W;

	spfl_pkg::state_t state_q, state_d;
	spfl_pkg::op_t    op_q;
	logic [SW-1:0]    key_q;
	logic             key_ok_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    used_count_q;
	logic             m_valid_q;
	logic             out_ok_q;
	logic [SW-1:0]    out_id_q;
	logic             out_last_q;

	logic             acc;
	logic             out_free;
	logic             emit, emit_ok, emit_last;
	logic [SW-1:0]    emit_id;
	logic             do_alloc, do_free, do_rot, seen_step_all;
	logic             pool_full, list_empty, list_last;

	logic [IDW-1:0]   key_id;
	logic [IDW-1:0]   used_val  [NUM_SLOTS];
	logic [IDW-1:0]   free_val  [NUM_SLOTS];
	logic             used_seen [NUM_SLOTS];
	logic             free_seen [NUM_SLOTS];
	logic [IDW-1:0]   used_bcast;

	assign acc        = s_tvalid && s_tready;
	assign out_free   = !m_valid_q || m_tready;
	assign key_id     = IDW'(key_q);
	assign pool_full  = (used_count_q == CW'(NUM_SLOTS));
	assign list_empty = (used_count_q == '0);
	assign list_last  = (cnt_q == used_count_q - CW'(1));
	assign used_bcast = do_alloc ? free_val[0] : used_val[0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			spfl_pkg::ST_IDLE: begin
				if (acc) begin
					case (spfl_pkg::op_t'(s_tdata[1:0]))
						spfl_pkg::OP_FREE: state_d = spfl_pkg::ST_SEARCH;
						spfl_pkg::OP_LIST: state_d = spfl_pkg::ST_LIST;
						default:           state_d = spfl_pkg::ST_EXEC;
					endcase
				end
			end
			spfl_pkg::ST_EXEC: begin
				if (out_free) state_d = spfl_pkg::ST_IDLE;
			end
			spfl_pkg::ST_SEARCH: begin
				if (cnt_q == CW'(NUM_SLOTS - 1)) state_d = spfl_pkg::ST_FINISH;
			end
			spfl_pkg::ST_FINISH: begin
				if (out_free) state_d = spfl_pkg::ST_IDLE;
			end
			spfl_pkg::ST_LIST: begin
				if (out_free && (list_empty || list_last)) state_d = spfl_pkg::ST_IDLE;
			end
			default: state_d = spfl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		emit          = 1'b0;
		emit_ok       = 1'b0;
		emit_id       = '0;
		emit_last     = 1'b1;
		do_alloc      = 1'b0;
		do_free       = 1'b0;
		do_rot        = 1'b0;
		seen_step_all = 1'b0;
		case (state_q)
			spfl_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			spfl_pkg::ST_EXEC: begin
				emit = out_free;
				if (op_q == spfl_pkg::OP_ALLOC && !pool_full) begin
					emit_ok  = 1'b1;
					emit_id  = SW'(free_val[0]);
					do_alloc = out_free;
				end
			end
			spfl_pkg::ST_SEARCH: begin
				seen_step_all = 1'b1;
			end
			spfl_pkg::ST_FINISH: begin
				emit = out_free;
				if (used_seen[NUM_SLOTS-1]) begin
					emit_ok = 1'b1;
					emit_id = key_q;
					do_free = out_free;
				end
			end
			spfl_pkg::ST_LIST: begin
				emit = out_free;
				if (!list_empty) begin
					emit_ok   = 1'b1;
					emit_id   = SW'(used_val[0]);
					emit_last = list_last;
					do_rot    = out_free;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= spfl_pkg::ST_IDLE;
			cnt_q        <= '0;
			used_count_q <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				cnt_q <= '0;
			end else if (seen_step_all || do_rot) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (do_alloc) begin
				used_count_q <= used_count_q + CW'(1);
			end else if (do_free) begin
				used_count_q <= used_count_q - CW'(1);
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q     <= spfl_pkg::op_t'(s_tdata[1:0]);
			key_q    <= s_tdata[6:2];
			key_ok_q <= (32'(s_tdata[6:2]) < NUM_SLOTS);
		end
		if (emit) begin
			out_ok_q   <= emit_ok;
			out_id_q   <= emit_id;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(spfl_pkg::TDATA_W - SW - 1)'(0), out_id_q, out_ok_q};
	assign m_tlast  = out_last_q;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		spfl_pkg::cell_ctrl_t used_ctrl, free_ctrl;
		logic [IDW-1:0]       used_left, used_right, free_left, free_right;
		logic                 used_sin, free_sin;

		if (i == 0) begin : g_first
			assign used_left = '0;
			assign free_left = key_id;
			assign used_sin  = 1'b0;
			assign free_sin  = 1'b0;
		end else begin : g_mid
			assign used_left = used_val[i-1];
			assign free_left = free_val[i-1];
			assign used_sin  = used_seen[i-1];
			assign free_sin  = free_seen[i-1];
		end

		if (i == NUM_SLOTS - 1) begin : g_last
			assign used_right = '0;
			assign free_right = '0;
		end else begin : g_inner
			assign used_right = used_val[i+1];
			assign free_right = free_val[i+1];
		end

		always_comb begin
			used_ctrl.seen_clr  = acc;
			used_ctrl.seen_step = seen_step_all;
			used_ctrl.cmp_en    = key_ok_q && (CW'(i) < used_count_q);
			used_ctrl.op        = spfl_pkg::CELL_HOLD;
			if (do_alloc && CW'(i) == used_count_q) begin
				used_ctrl.op = spfl_pkg::CELL_LOAD_BCAST;
			end else if (do_free && used_seen[i] && CW'(i + 1) < used_count_q) begin
				used_ctrl.op = spfl_pkg::CELL_LOAD_RIGHT;
			end else if (do_rot && CW'(i + 1) < used_count_q) begin
				used_ctrl.op = spfl_pkg::CELL_LOAD_RIGHT;
			end else if (do_rot && CW'(i + 1) == used_count_q) begin
				used_ctrl.op = spfl_pkg::CELL_LOAD_BCAST;
			end

			free_ctrl.seen_clr  = acc;
			free_ctrl.seen_step = 1'b0;
			free_ctrl.cmp_en    = 1'b0;
			free_ctrl.op        = spfl_pkg::CELL_HOLD;
			if (do_alloc) begin
				free_ctrl.op = spfl_pkg::CELL_LOAD_RIGHT;
			end else if (do_free) begin
				free_ctrl.op = spfl_pkg::CELL_LOAD_LEFT;
			end
		end

		spfl_cell #(.W(IDW), .RST(0)) u_used (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (used_ctrl),
			.key       (key_id),
			.left_val  (used_left),
			.right_val (used_right),
			.bcast_val (used_bcast),
			.seen_in   (used_sin),
			.val       (used_val[i]),
			.seen      (used_seen[i])
		);

		spfl_cell #(.W(IDW), .RST(i)) u_free (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (free_ctrl),
			.key       (key_id),
			.left_val  (free_left),
			.right_val (free_right),
			.bcast_val (free_val[0]),
			.seen_in   (free_sin),
			.val       (free_val[i]),
			.seen      (free_seen[i])
		);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_count_q <= CW'(NUM_SLOTS))
		else $error("In-use count exceeds the pool size.");

	a_fail_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[5:1] == '0 && m_tlast))
		else $error("Failing result carries a slot number or is not last.");

	a_search_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spfl_pkg::ST_SEARCH) |=> $stable(used_count_q))
		else $error("In-use count changed during the predecessor search.");

	a_free_chain_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!free_seen[NUM_SLOTS-1])
		else $error("Free stack raised a match flag.");

endmodule
`default_nettype wire
